// ===== hw/rtl/bsi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bsi_pkg: shared types and constants of the beam stroke interpolator
// Word structs, register indexes, commands and sequencer states.
// -----------------------------------------------------------------------------
package bsi_pkg;

	localparam int MAX_POINTS_DEF     = 4096;
	localparam int COORD_WIDTH_DEF    = 16;
	localparam int MAX_LINE_STEPS_DEF = 62;

	localparam int CW  = 16;   // coordinate field width
	localparam int IDXW = 12;  // point index width
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 15;

	localparam logic [14:0] LINE_STEP_RST = 15'd328;
	localparam logic [14:0] MOVE_STEP_RST = 15'd819;
	localparam logic [5:0]  MOVE_MIN_RST  = 6'd3;
	localparam logic [5:0]  MOVE_MAX_RST  = 6'd14;
	localparam logic [5:0]  SETTLE_RST    = 6'd4;
	localparam logic [5:0]  REG_CAP       = 6'd32;
	localparam logic [6:0]  DWELL_CAP     = 7'd64;

	typedef enum logic [2:0] {
		REG_LINE_STEP = 3'd0,
		REG_MOVE_STEP = 3'd1,
		REG_MOVE_MIN  = 3'd2,
		REG_MOVE_MAX  = 3'd3,
		REG_SETTLE    = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_BEGIN = 2'd0,
		CMD_MOVE  = 2'd1,
		CMD_LINE  = 2'd2,
		CMD_DWELL = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,      // dx^2 then dy^2 on the shared multiplier
		ST_SQ2,
		ST_SEARCH,  // step count search, one k per cycle
		ST_PRE,     // blank / start vertex of a line
		ST_NUM,     // build interpolation numerator
		ST_DIV,     // restoring divide, one bit per cycle
		ST_EMIT,    // present a point
		ST_SETTLE
	} state_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [15:0] x_coord;
		logic signed [15:0] y_coord;
		logic [6:0]         dwell_count;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] x_out;
		logic signed [15:0] y_out;
		logic               beam_on;
		logic [11:0]        point_index;
		logic               last;
	} out_word_t;

endpackage
`default_nettype wire

// ===== hw/rtl/beam_stroke_interpolator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// beam_stroke_interpolator_core: vector beam point generator
// Turns begin/move/line/dwell commands into a stream of beam points.
// -----------------------------------------------------------------------------
// Usage:
//   in_*  : one command word per accepted handshake (valid high, stall low).
//   out_* : point words; last marks the final point of a command.
//   cfg_* : write enable, register index, data; write only while idle.
// Timing:
//   A command is taken only in idle; in_stall is high while a command runs.
//   Moves and lines square dx, dy, then search the step count, one
//   candidate k per cycle, k from 0 up to 32 for a move, 62 for a line.
//   A line first emits its blank / start vertex points where needed. Each
//   interpolated point takes per axis a numerator step and a 24 bit
//   restoring divide, then an emit step. Settle and dwell points come
//   from the settle state, which also closes moves and lines. Begin stays
//   in idle and emits no point. Worst case is a 62 point line, and output
//   stalls lengthen any command.
// Stall: the output word holds while out_stall is high; the sequencer
//   waits on the held word. Points past the frame budget are dropped but
//   take the same cycles; the point in the last budget slot carries last.
//   Reset clears position, pen, frame flags, count and loads register
//   defaults; no clearing pass.
// -----------------------------------------------------------------------------
module beam_stroke_interpolator_core
	import bsi_pkg::*;
#(
	parameter int MAX_POINTS     = MAX_POINTS_DEF,
	parameter int MAX_LINE_STEPS = MAX_LINE_STEPS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire in_word_t          in_word,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output out_word_t              out_word,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_idx,
	input  wire logic [CFG_DW-1:0] cfg_data
);

	localparam int PCW = $clog2(MAX_POINTS + 1);
	localparam int DW  = 24;   // divide width: |2*d*k+n| < 2^24

	state_t state_q, state_nxt;

	logic [14:0] line_step_q, move_step_q;
	logic [5:0]  move_min_q, move_max_q, settle_q;

	logic signed [CW-1:0] cur_x_q, cur_y_q, tx_q, ty_q;
	logic signed [CW:0]   dx_q, dy_q;
	logic                 pen_q, started_q;
	logic [PCW-1:0]       pcnt_q;
	logic                 is_line_q, pre_blank_q;

	logic [33:0] d2_q;
	logic [6:0]  k_q, n_q, lim_q, rep_q;
	logic [14:0] step_q;
	logic [21:0] ks_q;              // running k*step during the search
	logic        side_q;            // 0 x, 1 y in divide
	logic [DW-1:0] rem_q, quo_q, num_q;
	logic          neg_q;
	logic [4:0]    bit_q;
	logic signed [CW-1:0] px_q, py_q;
	logic          on_q;
	logic          emit_q;           // output word loaded

	// shared multiplier: squares of dx, dy and k*step, and d*k
	logic signed [22:0] ma, mb;
	logic signed [45:0] mp;
	assign mp = ma * mb;

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			ST_SQ:     begin ma = 23'(dx_q); mb = 23'(dx_q); end
			ST_SQ2:    begin ma = 23'(dy_q); mb = 23'(dy_q); end
			ST_SEARCH: begin ma = {1'b0, ks_q}; mb = {1'b0, ks_q}; end
			ST_NUM:    begin ma = side_q ? 23'(dy_q) : 23'(dx_q); mb = 23'({16'd0, k_q}); end
			default:   ;
		endcase
	end

	logic [5:0] lo_c, hi_c, st_c;
	assign lo_c = (move_min_q > REG_CAP) ? REG_CAP : move_min_q;
	assign hi_c = (move_max_q > REG_CAP) ? REG_CAP : move_max_q;
	assign st_c = (settle_q > REG_CAP) ? REG_CAP : settle_q;

	logic found;
	assign found = ($unsigned(mp[43:0]) >= {10'd0, d2_q});

	// clamp of a raw step count
	logic [6:0] n_raw, n_cl;
	assign n_raw = found ? k_q : k_q + 7'd1;
	always_comb begin
		n_cl = n_raw;
		if (is_line_q) begin
			if (n_cl < 7'd1) n_cl = 7'd1;
			if (n_cl > 7'(MAX_LINE_STEPS)) n_cl = 7'(MAX_LINE_STEPS);
		end else begin
			if (n_cl < {1'b0, lo_c}) n_cl = {1'b0, lo_c};
			if (n_cl > {1'b0, hi_c}) n_cl = {1'b0, hi_c};
		end
	end
	logic search_done;
	assign search_done = found || (k_q == lim_q);

	logic room;
	assign room = (pcnt_q < PCW'(MAX_POINTS));
	logic busy_out;
	assign busy_out = emit_q && out_stall;

	// 2*d*k + n, sign kept from the product (|d*k| < 2^22)
	logic signed [DW:0] num_s;
	assign num_s = {mp[DW-2], mp[DW-2:0], 1'b0} + (DW+1)'(n_q);

	logic [DW-1:0] qfin;
	logic signed [CW-1:0] pres;

	logic [DW-1:0] den;
	assign den = DW'({n_q, 1'b0});
	logic [DW:0] shrem;
	assign shrem = {rem_q, num_q[DW-1]};
	logic geq;
	assign geq = shrem >= {1'b0, den};

	logic signed [CW-1:0] base;
	assign base = side_q ? cur_y_q : cur_x_q;
	always_comb begin
		qfin = geq ? {quo_q[DW-2:0], 1'b1} : {quo_q[DW-2:0], 1'b0};
		pres = base + (neg_q ? -CW'(qfin) : CW'(qfin));
	end

	logic point_rep_last;
	assign point_rep_last = (rep_q <= 7'd1);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				unique case (cmd_t'(in_word.cmd))
					CMD_BEGIN: state_nxt = ST_IDLE;
					CMD_DWELL: state_nxt = (in_word.dwell_count == 7'd0) ? ST_IDLE : ST_SETTLE;
					default:   state_nxt = ST_SQ;
				endcase
			end
			ST_SQ:     state_nxt = ST_SQ2;
			ST_SQ2:    state_nxt = ST_SEARCH;
			ST_SEARCH: if (search_done) state_nxt = is_line_q ? ST_PRE : ST_NUM;
			ST_PRE:    if (!busy_out && !pre_blank_q && pen_q) state_nxt = ST_NUM;
			ST_NUM:    state_nxt = (n_q == 7'd0) ? ST_SETTLE : ST_DIV;
			ST_DIV:    if (bit_q == 5'd0 && side_q) state_nxt = ST_EMIT;
			           else if (bit_q == 5'd0) state_nxt = ST_NUM;
			ST_EMIT:   if (!busy_out) state_nxt = (k_q == n_q) ? ST_SETTLE : ST_NUM;
			ST_SETTLE: if (!busy_out && (rep_q == 7'd0 || point_rep_last)) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
	end
	assign out_valid = emit_q;

	// point request this cycle
	logic pt_go;
	logic signed [CW-1:0] pt_x, pt_y;
	logic pt_on, pt_last;
	always_comb begin
		pt_go = 1'b0; pt_x = cur_x_q; pt_y = cur_y_q; pt_on = 1'b1; pt_last = 1'b0;
		unique case (state_q)
			ST_PRE: if (!busy_out) begin
				pt_go = pre_blank_q || !pen_q;
				pt_on = !pre_blank_q;
			end
			ST_EMIT: if (!busy_out) begin
				pt_go = 1'b1; pt_x = px_q; pt_y = py_q; pt_on = on_q;
				pt_last = (k_q == n_q) && (is_line_q || rep_q == 7'd0);
			end
			ST_SETTLE: if (!busy_out && rep_q != 7'd0) begin
				pt_go = 1'b1;
				pt_x = is_line_q ? cur_x_q : tx_q;
				pt_y = is_line_q ? cur_y_q : ty_q;
				pt_on = is_line_q;
				pt_last = point_rep_last;
			end
			default: ;
		endcase
	end

	// the point taking the final budget slot is the last one of its command
	logic [PCW-1:0] pcnt_nx;
	assign pcnt_nx = pcnt_q + PCW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			line_step_q <= LINE_STEP_RST; move_step_q <= MOVE_STEP_RST;
			move_min_q <= MOVE_MIN_RST; move_max_q <= MOVE_MAX_RST; settle_q <= SETTLE_RST;
			cur_x_q <= '0; cur_y_q <= '0; pen_q <= 1'b0; started_q <= 1'b0;
			pcnt_q <= '0; emit_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_LINE_STEP: line_step_q <= cfg_data;
					REG_MOVE_STEP: move_step_q <= cfg_data;
					REG_MOVE_MIN:  move_min_q <= cfg_data[5:0];
					REG_MOVE_MAX:  move_max_q <= cfg_data[5:0];
					REG_SETTLE:    settle_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (pt_go && room) begin
				emit_q <= 1'b1;
				out_word <= '{x_out: pt_x, y_out: pt_y, beam_on: pt_on,
					point_index: pcnt_q[IDXW-1:0],
					last: pt_last || (pcnt_nx == PCW'(MAX_POINTS))};
				pcnt_q <= pcnt_nx;
			end else if (emit_q && !out_stall) begin
				emit_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					tx_q <= in_word.x_coord; ty_q <= in_word.y_coord;
					dx_q <= (CW+1)'(in_word.x_coord) - (CW+1)'(cur_x_q);
					dy_q <= (CW+1)'(in_word.y_coord) - (CW+1)'(cur_y_q);
					is_line_q <= (in_word.cmd == CMD_LINE) || (in_word.cmd == CMD_DWELL);
					k_q <= '0; n_q <= '0; ks_q <= '0;
					step_q <= (in_word.cmd == CMD_LINE) ? line_step_q : move_step_q;
					lim_q <= (in_word.cmd == CMD_LINE) ? 7'(MAX_LINE_STEPS) : 7'(REG_CAP);
					pre_blank_q <= !started_q;
					side_q <= 1'b0;
					unique case (cmd_t'(in_word.cmd))
						CMD_BEGIN: begin
							pcnt_q <= '0; cur_x_q <= '0; cur_y_q <= '0;
							pen_q <= 1'b0; started_q <= 1'b0;
						end
						CMD_DWELL: begin
							rep_q <= (in_word.dwell_count > DWELL_CAP) ? DWELL_CAP
								: in_word.dwell_count;
						end
						default: ;
					endcase
				end
				ST_SQ:  d2_q <= 34'($unsigned(mp[33:0]));
				ST_SQ2: d2_q <= d2_q + 34'($unsigned(mp[33:0]));
				ST_SEARCH: begin
					if (search_done) begin
						n_q <= n_cl; k_q <= 7'd1;
						rep_q <= is_line_q ? 7'd0 : {1'b0, st_c};
					end else begin
						k_q <= k_q + 7'd1;
						ks_q <= ks_q + 22'(step_q);
					end
				end
				ST_PRE: if (!busy_out) begin
					if (pre_blank_q) begin pre_blank_q <= 1'b0; started_q <= 1'b1; end
					else if (!pen_q) pen_q <= 1'b1;
				end
				ST_NUM: begin
					// |2*d*k + n| ; halves to +inf via ceil on negatives
					if (num_s[DW]) begin
						num_q <= DW'(-num_s + (DW+1)'({n_q, 1'b0}) - (DW+1)'(1));
						neg_q <= 1'b1;
					end else begin
						num_q <= num_s[DW-1:0];
						neg_q <= 1'b0;
					end
					rem_q <= '0; quo_q <= '0; bit_q <= 5'(DW-1);
				end
				ST_DIV: begin
					rem_q <= geq ? DW'(shrem - {1'b0, den}) : DW'(shrem);
					quo_q <= qfin;
					num_q <= {num_q[DW-2:0], 1'b0};
					bit_q <= bit_q - 5'd1;
					if (bit_q == 5'd0) begin
						if (side_q) py_q <= pres; else px_q <= pres;
						side_q <= !side_q;
						on_q <= is_line_q;
					end
				end
				ST_EMIT: if (!busy_out) begin
					k_q <= k_q + 7'd1;
					if (k_q == n_q) begin
						cur_x_q <= tx_q; cur_y_q <= ty_q;
						if (is_line_q) pen_q <= 1'b1;
						else begin pen_q <= 1'b0; started_q <= 1'b1; end
					end
				end
				ST_SETTLE: if (!busy_out) begin
					if (rep_q != 7'd0) rep_q <= rep_q - 7'd1;
					if (!is_line_q) begin
						cur_x_q <= tx_q; cur_y_q <= ty_q; pen_q <= 1'b0; started_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("accept while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_word)))
		else $error("output word changed under stall");
	a_budget: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= PCW'(MAX_POINTS)) else $error("point count past budget");

endmodule
`default_nettype wire

// ===== sim/beam_stroke_interpolator_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// beam_stroke_interpolator_checker: point stream predictor and scoreboard
// Watches command and point words and configuration writes, predicts the
// beam points of every accepted command and compares them in order.
// -----------------------------------------------------------------------------
module beam_stroke_interpolator_checker
	import bsi_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  in_word_t            in_word,
	input  logic                out_valid,
	input  logic                out_stall,
	input  out_word_t           out_word,
	input  logic                cfg_we,
	input  logic [CFG_AW-1:0]   cfg_idx,
	input  logic [CFG_DW-1:0]   cfg_data,
	output int                  fail_count,
	output int                  pending_points
);

	out_word_t point_q[$];

	logic [14:0] line_step_r, move_step_r;
	logic [5:0]  move_min_r, move_max_r, settle_r;
	longint      pos_x, pos_y;
	bit          pen_low, started;
	int          slot_count;

	assign pending_points = point_q.size();

	function automatic int find_steps(longint dx, longint dy, longint stp, int lim);
		longint d2, s;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		if (dx >= 2097152 || dy >= 2097152)
			return lim + 1;
		d2 = dx * dx + dy * dy;
		for (int k = 0; k <= lim; k++) begin
			s = k * stp;
			if (s * s >= d2)
				return k;
		end
		return lim + 1;
	endfunction

	// round half toward plus infinity
	function automatic longint lerp(longint base, longint d, int k, int n);
		longint num, den;
		num = 2 * d * k + n;
		den = 2 * n;
		if (num >= 0)
			return base + num / den;
		return base - ((-num + den - 1) / den);
	endfunction

	task automatic push_point(input longint x, input longint y, input bit on, inout int cnt);
		out_word_t w;
		if (slot_count >= 4096 || cnt >= 64)
			return;
		w.x_out = x[15:0];
		w.y_out = y[15:0];
		w.beam_on = on;
		w.point_index = slot_count[11:0];
		w.last = 1'b0;
		point_q.push_back(w);
		slot_count++;
		cnt++;
	endtask

	task automatic predict_points(input in_word_t w);
		longint tx, ty, dx, dy;
		int cnt, n, lo, hi, st, dw;
		tx = w.x_coord;
		ty = w.y_coord;
		dx = tx - pos_x;
		dy = ty - pos_y;
		cnt = 0;
		case (cmd_t'(w.cmd))
			CMD_BEGIN: begin
				slot_count = 0; pos_x = 0; pos_y = 0;
				pen_low = 0; started = 0;
			end
			CMD_MOVE: begin
				lo = move_min_r > 32 ? 32 : move_min_r;
				hi = move_max_r > 32 ? 32 : move_max_r;
				st = settle_r > 32 ? 32 : settle_r;
				n = find_steps(dx, dy, move_step_r, 32);
				if (n < lo) n = lo;
				if (n > hi) n = hi;
				for (int k = 1; k <= n; k++)
					push_point(lerp(pos_x, dx, k, n), lerp(pos_y, dy, k, n), 0, cnt);
				for (int k = 0; k < st; k++)
					push_point(tx, ty, 0, cnt);
				pos_x = tx; pos_y = ty;
				pen_low = 0; started = 1;
			end
			CMD_LINE: begin
				if (!started) begin
					push_point(pos_x, pos_y, 0, cnt);
					started = 1;
				end
				if (!pen_low) begin
					push_point(pos_x, pos_y, 1, cnt);
					pen_low = 1;
				end
				n = find_steps(dx, dy, line_step_r, 62);
				if (n < 1) n = 1;
				if (n > 62) n = 62;
				for (int k = 1; k <= n; k++)
					push_point(lerp(pos_x, dx, k, n), lerp(pos_y, dy, k, n), 1, cnt);
				pos_x = tx; pos_y = ty;
			end
			default: begin
				dw = w.dwell_count > 64 ? 64 : w.dwell_count;
				for (int k = 0; k < dw; k++)
					push_point(pos_x, pos_y, 1, cnt);
			end
		endcase
		if (cnt > 0)
			point_q[point_q.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t exp_w;
		if (!arst_n) begin
			line_step_r <= LINE_STEP_RST;
			move_step_r <= MOVE_STEP_RST;
			move_min_r <= MOVE_MIN_RST;
			move_max_r <= MOVE_MAX_RST;
			settle_r <= SETTLE_RST;
			pos_x = 0; pos_y = 0; pen_low = 0; started = 0; slot_count = 0;
			fail_count <= 0;
			point_q.delete();
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_LINE_STEP: line_step_r <= cfg_data;
					REG_MOVE_STEP: move_step_r <= cfg_data;
					REG_MOVE_MIN:  move_min_r <= cfg_data[5:0];
					REG_MOVE_MAX:  move_max_r <= cfg_data[5:0];
					REG_SETTLE:    settle_r <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_points(in_word);
			if (out_valid && !out_stall) begin
				if (point_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected point word %p", out_word);
					fail_count <= fail_count + 1;
				end else begin
					exp_w = point_q.pop_front();
					if (exp_w !== out_word) begin
						if (fail_count < 10)
							$display("point mismatch: expected %p got %p", exp_w, out_word);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== sim/beam_stroke_interpolator_core_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// beam_stroke_interpolator_core_tb: stimulus and verdict
// Drives command words and register settings in phases, with random gaps,
// receiver stalls and a long hold-off; a checker predicts the points.
// -----------------------------------------------------------------------------
module beam_stroke_interpolator_core_tb;
	import bsi_pkg::*;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              in_valid = 0;
	logic              in_stall;
	in_word_t          in_word = '0;
	logic              out_valid;
	logic              out_stall = 0;
	out_word_t         out_word;
	logic              cfg_we = 0;
	logic [CFG_AW-1:0] cfg_idx = '0;
	logic [CFG_DW-1:0] cfg_data = '0;
	int                fail_count, pending_points;
	int                idle_cycles = 0;
	bit                hold_off = 0;   // long receiver hold-off request

	always #2 clk = ~clk;

	beam_stroke_interpolator_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	beam_stroke_interpolator_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_points(pending_points)
	);

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_stall <= 1;
				repeat (600) @(posedge clk);
				out_stall <= 0;
				hold_off = 0;
			end
			g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			out_stall <= (g > 0);
			repeat (g > 0 ? g : 1) @(posedge clk);
		end
	end

	// watchdog: cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 50000) begin
			$display("simulation failed");
			$finish;
		end
	end

	// valid stays high after the accepting edge; the caller drops it or
	// offers the next word at that same edge
	task automatic send_word(input cmd_t c, input logic [15:0] x, input logic [15:0] y,
			input logic [6:0] d);
		in_word <= '{cmd: c, x_coord: x, y_coord: y, dwell_count: d};
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_gapped(input cmd_t c, input logic [15:0] x, input logic [15:0] y,
			input logic [6:0] d);
		int g;
		send_word(c, x, y, d);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	// wait until every point is out and the block is idle again
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending_points != 0 || in_stall) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t r, input logic [CFG_DW-1:0] v);
		cfg_we <= 1;
		cfg_idx <= r;
		cfg_data <= v;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [14:0] ls, input logic [14:0] ms,
			input logic [5:0] mn, input logic [5:0] mx, input logic [5:0] st);
		write_reg(REG_LINE_STEP, ls);
		write_reg(REG_MOVE_STEP, ms);
		write_reg(REG_MOVE_MIN, mn);
		write_reg(REG_MOVE_MAX, mx);
		write_reg(REG_SETTLE, st);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// random command: mostly moves and lines, rare begins
	task automatic random_word(input bit short_hops);
		int r;
		cmd_t c;
		logic [15:0] x, y;
		r = $urandom_range(0, 99);
		c = r < 4 ? CMD_BEGIN : r < 40 ? CMD_MOVE : r < 85 ? CMD_LINE : CMD_DWELL;
		if (short_hops) begin
			x = 16'($signed($urandom_range(0, 4000)) - 2000);
			y = 16'($signed($urandom_range(0, 4000)) - 2000);
		end else begin
			x = 16'($urandom);
			y = 16'($urandom);
		end
		send_gapped(c, x, y, 7'($urandom_range(0, 127)));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: unstarted line, field extremes, all commands, dwell caps
		send_gapped(CMD_LINE, 16'h0100, 16'h0080, 7'd0);
		send_gapped(CMD_LINE, 16'h7FFF, 16'h8000, 7'd0);
		send_gapped(CMD_DWELL, 16'h0, 16'h0, 7'd0);
		send_gapped(CMD_DWELL, 16'h0, 16'h0, 7'd64);
		send_gapped(CMD_DWELL, 16'hFFFF, 16'hFFFF, 7'd127);
		send_gapped(CMD_MOVE, 16'h8000, 16'h7FFF, 7'd5);
		send_gapped(CMD_MOVE, 16'h8000, 16'h7FFF, 7'd0);
		send_gapped(CMD_LINE, 16'h8000, 16'h7FFF, 7'd0);
		send_gapped(CMD_LINE, 16'hFFFF, 16'h0001, 7'd0);
		send_gapped(CMD_BEGIN, 16'h1234, 16'h5678, 7'd3);
		send_gapped(CMD_MOVE, 16'h0003, 16'hFFFD, 7'd0);
		send_gapped(CMD_LINE, 16'hFFFB, 16'h0007, 7'd0);
		drain();

		// zero steps and zero counts
		set_regs(15'd0, 15'd0, 6'd0, 6'd0, 6'd0);
		send_gapped(CMD_MOVE, 16'h0400, 16'h0400, 7'd0);
		send_gapped(CMD_LINE, 16'h0000, 16'h0000, 7'd0);
		send_gapped(CMD_LINE, 16'h0000, 16'h0000, 7'd0);
		send_gapped(CMD_LINE, 16'hC000, 16'h3000, 7'd0);
		drain();

		// maximum steps, register values past the cap
		set_regs(15'h7FFF, 15'h7FFF, 6'h3F, 6'h3F, 6'h3F);
		send_gapped(CMD_MOVE, 16'h7FFF, 16'h7FFF, 7'd0);
		send_gapped(CMD_LINE, 16'h8000, 16'h8000, 7'd0);
		send_gapped(CMD_MOVE, 16'h0000, 16'h0000, 7'd0);
		drain();

		// frame budget: fill past 4096 points with long dwells, fine lines
		set_regs(15'd1, 15'd1, 6'd32, 6'd32, 6'd32);
		send_word(CMD_BEGIN, 16'h0, 16'h0, 7'd0);
		for (int i = 0; i < 66; i++)
			send_word(CMD_DWELL, 16'h0, 16'h0, 7'd64);
		send_word(CMD_MOVE, 16'h0100, 16'h0100, 7'd0);
		send_word(CMD_LINE, 16'h0200, 16'h0000, 7'd0);
		send_word(CMD_BEGIN, 16'h0, 16'h0, 7'd0);
		drain();

		// long receiver hold-off while commands keep coming
		set_regs(15'd328, 15'd819, 6'd3, 6'd14, 6'd4);
		hold_off = 1;
		for (int i = 0; i < 20; i++)
			send_word(CMD_LINE, 16'($urandom), 16'($urandom), 7'd0);
		drain();

		// random phases with varied settings
		for (int ph = 0; ph < 6; ph++) begin
			set_regs(15'($urandom_range(1, 32767)), 15'($urandom_range(1, 32767)),
				6'($urandom_range(1, 32)), 6'($urandom_range(1, 32)),
				6'($urandom_range(0, 32)));
			if (ph == 2)
				set_regs(15'($urandom_range(64, 2000)), 15'($urandom_range(64, 2000)),
					6'($urandom_range(1, 8)), 6'($urandom_range(8, 32)),
					6'($urandom_range(0, 6)));
			for (int i = 0; i < 24; i++)
				random_word(ph[0]);
			drain();
		end
		set_regs(LINE_STEP_RST, MOVE_STEP_RST, MOVE_MIN_RST, MOVE_MAX_RST, SETTLE_RST);
		for (int i = 0; i < 20; i++)
			random_word(1);

		drain();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
